>>> rtl/chr_pkg.sv
// ----------------------------------------------------------------------------
// chr_pkg
// Shared types and constants of the checksum history recorder: operation
// codes, controller states, and the command and status groups that run
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package chr_pkg;

  localparam int unsigned WORD_W     = 32;
  localparam int unsigned COUNT_W    = 64;
  localparam int unsigned POS_W      = 6;
  localparam int unsigned BCNT_W     = 3;
  localparam int unsigned BLKNUM_W   = 16;
  localparam int unsigned IN_TDATA_W  = 56;   // 32 + 3 + 16 = 51, padded to bytes
  localparam int unsigned OUT_TDATA_W = 104;  // 32 + 64 + 6 = 102, padded to bytes

  // in_tdata field offsets
  localparam int unsigned IN_WORD_LSB = 0;
  localparam int unsigned IN_BCNT_LSB = 32;
  localparam int unsigned IN_BLK_LSB  = 35;

  localparam logic [BCNT_W-1:0] FULL_WORD_BYTES = 3'd4;

  typedef enum logic [1:0] {
    OP_RECORD   = 2'd0,
    OP_CHECKSUM = 2'd1,
    OP_BLOCK    = 2'd2,
    OP_CLEAR    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HASH_RD,
    ST_HASH_ACC,
    ST_HASH_OUT,
    ST_BLK_RD,
    ST_BLK_OUT,
    ST_BAD_OUT
  } state_t;

  typedef enum logic [1:0] {
    SRC_HASH,
    SRC_ENTRY,
    SRC_BAD
  } out_src_t;

  typedef struct packed {
    logic     rec_word;    // fold one record word, commit on last
    logic     clear;       // return history state to reset
    logic     walk_start;  // start a walk over all blocks
    logic     blk_start;   // start a walk over one block
    logic     rd_en;       // read the entry at the walk address
    logic     hash_clr;    // restart the block hash
    logic     hash_acc;    // fold the read entry into the hash
    logic     ent_step;    // advance entry counter
    logic     blk_step;    // advance block counter
    logic     out_load;    // load the output register
    out_src_t out_src;
    logic     out_last;
  } chr_cmd_t;

  typedef struct packed {
    logic slot_free;  // output register empty or being taken
    logic ent_last;   // entry counter at last entry of a block
    logic blk_last;   // block counter at last block
    logic bad_blk;    // requested block number out of range
  } chr_sts_t;

endpackage

>>> rtl/chr_ram.sv
// ----------------------------------------------------------------------------
// chr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module chr_ram #(
  parameter int unsigned WIDTH  = 32,
  parameter int unsigned DEPTH  = 1024,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/chr_ctrl.sv
// ----------------------------------------------------------------------------
// chr_ctrl
// Controller: accepts requests, sequences the memory walks of checksum and
// block requests, and drives datapath commands.
// ----------------------------------------------------------------------------
module chr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [1:0]        in_tuser,
  input  chr_pkg::chr_sts_t sts,
  output chr_pkg::chr_cmd_t cmd
);

  import chr_pkg::*;

  state_t state_r, state_nxt;
  logic   accept;
  op_t    op;

  assign op        = op_t'(in_tuser);
  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && op == OP_CHECKSUM) begin
          state_nxt = ST_HASH_RD;
        end else if (accept && op == OP_BLOCK) begin
          state_nxt = sts.bad_blk ? ST_BAD_OUT : ST_BLK_RD;
        end
      end
      ST_HASH_RD:  state_nxt = ST_HASH_ACC;
      ST_HASH_ACC: state_nxt = sts.ent_last ? ST_HASH_OUT : ST_HASH_RD;
      ST_HASH_OUT: begin
        if (sts.slot_free) begin
          state_nxt = sts.blk_last ? ST_IDLE : ST_HASH_RD;
        end
      end
      ST_BLK_RD:   state_nxt = ST_BLK_OUT;
      ST_BLK_OUT: begin
        if (sts.slot_free) begin
          state_nxt = sts.ent_last ? ST_IDLE : ST_BLK_RD;
        end
      end
      ST_BAD_OUT: begin
        if (sts.slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd = '0;
    cmd.out_src = SRC_HASH;
    case (state_r)
      ST_IDLE: begin
        cmd.rec_word   = accept && (op == OP_RECORD);
        cmd.clear      = accept && (op == OP_CLEAR);
        cmd.walk_start = accept && (op == OP_CHECKSUM);
        cmd.hash_clr   = accept && (op == OP_CHECKSUM);
        cmd.blk_start  = accept && (op == OP_BLOCK) && !sts.bad_blk;
      end
      ST_HASH_RD:  cmd.rd_en = 1'b1;
      ST_HASH_ACC: begin
        cmd.hash_acc = 1'b1;
        cmd.ent_step = 1'b1;
      end
      ST_HASH_OUT: begin
        cmd.out_load = sts.slot_free;
        cmd.out_src  = SRC_HASH;
        cmd.out_last = sts.blk_last;
        cmd.blk_step = sts.slot_free;
        cmd.hash_clr = sts.slot_free;
      end
      ST_BLK_RD:   cmd.rd_en = 1'b1;
      ST_BLK_OUT: begin
        cmd.out_load = sts.slot_free;
        cmd.out_src  = SRC_ENTRY;
        cmd.out_last = sts.ent_last;
        cmd.ent_step = sts.slot_free;
      end
      ST_BAD_OUT: begin
        cmd.out_load = sts.slot_free;
        cmd.out_src  = SRC_BAD;
        cmd.out_last = 1'b1;
      end
      default: cmd = '0;
    endcase
  end

endmodule

>>> rtl/chr_dp.sv
// ----------------------------------------------------------------------------
// chr_dp
// Datapath: record checksum fold, history ring with fill tracking, record
// counter, walk counters, block hash and the output register.
// ----------------------------------------------------------------------------
module chr_dp #(
  parameter int unsigned NUM_BLOCKS        = 16,
  parameter int unsigned ENTRIES_PER_BLOCK = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [chr_pkg::IN_TDATA_W-1:0]      in_tdata,
  input  logic                                in_tlast,
  input  chr_pkg::chr_cmd_t                   cmd,
  output chr_pkg::chr_sts_t                   sts,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [chr_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic                                out_tlast,
  output logic                                out_tuser
);

  import chr_pkg::*;

  localparam int unsigned DEPTH = NUM_BLOCKS * ENTRIES_PER_BLOCK;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned EW    = (ENTRIES_PER_BLOCK > 1) ? $clog2(ENTRIES_PER_BLOCK) : 1;
  localparam int unsigned BW    = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;

  // input fields
  logic [WORD_W-1:0]   in_word;
  logic [BCNT_W-1:0]   in_bcnt;
  logic [BLKNUM_W-1:0] in_blk;

  assign in_word = in_tdata[IN_WORD_LSB +: WORD_W];
  assign in_bcnt = in_tdata[IN_BCNT_LSB +: BCNT_W];
  assign in_blk  = in_tdata[IN_BLK_LSB +: BLKNUM_W];

  // history state
  logic [WORD_W-1:0]  run_xor_r, run_xor_nxt, fold;
  logic [AW-1:0]      wr_idx_r, wr_idx_nxt;
  logic               wrapped_r, wrapped_nxt;
  logic [COUNT_W-1:0] rec_cnt_r, rec_cnt_nxt;

  // walk state
  logic [AW-1:0]      addr_r, addr_nxt;
  logic [EW-1:0]      ent_r, ent_nxt;
  logic [BW-1:0]      blk_r, blk_nxt;
  logic               rd_ok_r;
  logic [WORD_W-1:0]  hash_r, hash_nxt;
  logic [WORD_W-1:0]  ram_rdata, entry;
  logic               ram_we;

  // output register
  logic               out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0]  out_val_r;
  logic [COUNT_W-1:0] out_cnt_r;
  logic [POS_W-1:0]   out_pos_r;
  logic               out_last_r;
  logic               out_bad_r;

  // fold of one record word; short words fold byte-wise into the low byte
  always_comb begin
    if (in_bcnt >= FULL_WORD_BYTES) begin
      fold = in_word;
    end else begin
      fold = '0;
      if (in_bcnt > 3'd0) fold[7:0] = fold[7:0] ^ in_word[7:0];
      if (in_bcnt > 3'd1) fold[7:0] = fold[7:0] ^ in_word[15:8];
      if (in_bcnt > 3'd2) fold[7:0] = fold[7:0] ^ in_word[23:16];
    end
  end

  assign ram_we = cmd.rec_word && in_tlast;

  always_comb begin
    run_xor_nxt = run_xor_r;
    wr_idx_nxt  = wr_idx_r;
    wrapped_nxt = wrapped_r;
    rec_cnt_nxt = rec_cnt_r;
    if (cmd.clear) begin
      run_xor_nxt = '0;
      wr_idx_nxt  = '0;
      wrapped_nxt = 1'b0;
      rec_cnt_nxt = '0;
    end else if (cmd.rec_word) begin
      run_xor_nxt = run_xor_r ^ fold;
      if (in_tlast) begin
        run_xor_nxt = '0;
        rec_cnt_nxt = rec_cnt_r + COUNT_W'(1);
        if (wr_idx_r == AW'(DEPTH - 1)) begin
          wr_idx_nxt  = '0;
          wrapped_nxt = 1'b1;
        end else begin
          wr_idx_nxt = wr_idx_r + AW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_xor_r <= '0;
      wr_idx_r  <= '0;
      wrapped_r <= 1'b0;
      rec_cnt_r <= '0;
    end else begin
      run_xor_r <= run_xor_nxt;
      wr_idx_r  <= wr_idx_nxt;
      wrapped_r <= wrapped_nxt;
      rec_cnt_r <= rec_cnt_nxt;
    end
  end

  chr_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_idx_r),
    .wdata (run_xor_r ^ fold),
    .re    (cmd.rd_en),
    .raddr (addr_r),
    .rdata (ram_rdata)
  );

  // entries never written since clear read as zero
  assign entry = rd_ok_r ? ram_rdata : '0;

  always_comb begin
    addr_nxt = addr_r;
    ent_nxt  = ent_r;
    blk_nxt  = blk_r;
    hash_nxt = hash_r;
    if (cmd.walk_start) begin
      addr_nxt = '0;
      ent_nxt  = '0;
      blk_nxt  = '0;
    end else if (cmd.blk_start) begin
      addr_nxt = AW'(32'(in_blk[BW-1:0]) * ENTRIES_PER_BLOCK);
      ent_nxt  = '0;
    end else begin
      if (cmd.rd_en) begin
        addr_nxt = addr_r + AW'(1);
      end
      if (cmd.ent_step) begin
        ent_nxt = sts.ent_last ? '0 : ent_r + EW'(1);
      end
      if (cmd.blk_step) begin
        blk_nxt = sts.blk_last ? '0 : blk_r + BW'(1);
      end
    end
    if (cmd.hash_clr) begin
      hash_nxt = '0;
    end else if (cmd.hash_acc) begin
      hash_nxt = (hash_r << 5) + hash_r + entry;
    end
  end

  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
    ent_r  <= ent_nxt;
    blk_r  <= blk_nxt;
    hash_r <= hash_nxt;
    if (cmd.rd_en) begin
      rd_ok_r <= wrapped_r || (addr_r < wr_idx_r);
    end
  end

  // output register
  assign out_valid_nxt = cmd.out_load || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_last_r <= cmd.out_last;
      case (cmd.out_src)
        SRC_HASH: begin
          out_val_r <= hash_r;
          out_cnt_r <= rec_cnt_r;
          out_pos_r <= POS_W'(blk_r);
          out_bad_r <= 1'b0;
        end
        SRC_ENTRY: begin
          out_val_r <= entry;
          out_cnt_r <= rec_cnt_r;
          out_pos_r <= POS_W'(ent_r);
          out_bad_r <= 1'b0;
        end
        default: begin
          out_val_r <= '0;
          out_cnt_r <= '0;
          out_pos_r <= '0;
          out_bad_r <= 1'b1;
        end
      endcase
    end
  end

  assign sts.slot_free = !out_valid_r || out_tready;
  assign sts.ent_last  = (ent_r == EW'(ENTRIES_PER_BLOCK - 1));
  assign sts.blk_last  = (blk_r == BW'(NUM_BLOCKS - 1));
  assign sts.bad_blk   = (in_blk >= BLKNUM_W'(NUM_BLOCKS));

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_TDATA_W - WORD_W - COUNT_W - POS_W)'(0),
                       out_pos_r, out_cnt_r, out_val_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_bad_r;

endmodule

>>> rtl/checksum_history_recorder.sv
// ----------------------------------------------------------------------------
// checksum_history_recorder
// Ring history of 32-bit record checksums with block hash and block dump.
//
// Input stream (in_*): one request per beat. in_tuser carries the operation:
// record word, checksum request, block request or clear. A record word is
// folded into the running XOR checksum; in_tlast on a record word commits the
// checksum into the ring and bumps the 64-bit record counter. Record words
// and clears produce no result.
// Result stream (out_*): a checksum request returns NUM_BLOCKS results, one
// times-33 hash per block; a block request returns ENTRIES_PER_BLOCK entries
// of that block, or a single result flagged on out_tuser when the block
// number is out of range. out_tlast marks the final result of a request.
// Walks: each entry is read from the history RAM and then folded into the
// hash or emitted; a checksum request also emits one hash per block. The
// input is held off (in_tready low) while a walk runs.
// Reset and clear: record counter, write index and running checksum go to
// zero at once; a fill mark makes entries not yet written since then read as
// zero, so no clearing pass runs. A stalled receiver holds the output register
// and pauses the walk; requests are taken again once the final result loads.
// ----------------------------------------------------------------------------
module checksum_history_recorder #(
  parameter int unsigned NUM_BLOCKS        = 16,
  parameter int unsigned ENTRIES_PER_BLOCK = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // request stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [chr_pkg::IN_TDATA_W-1:0]  in_tdata,   // data_word[31:0], byte_count[34:32],
                                                      // block_number[50:35], zero pad
  input  logic                            in_tlast,   // last_word
  input  logic [1:0]                      in_tuser,   // op
  // result stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [chr_pkg::OUT_TDATA_W-1:0] out_tdata,  // value[31:0], record_count[95:32],
                                                      // position[101:96], zero pad
  output logic                            out_tlast,  // last_result
  output logic                            out_tuser   // bad_block
);

  import chr_pkg::*;

  chr_cmd_t cmd;
  chr_sts_t sts;

  // sequence requests and memory walks
  chr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .sts       (sts),
    .cmd       (cmd)
  );

  // hold history, counters, hash and the output register
  chr_dp #(
    .NUM_BLOCKS        (NUM_BLOCKS),
    .ENTRIES_PER_BLOCK (ENTRIES_PER_BLOCK)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule
